>>> rtl/amd_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// amd_pkg
// Shared types and constants for the accelerometer axis motor drive.
// ============================================================================
package amd_pkg;

    // Input and result field widths
    localparam int ACC_W   = 16;
    localparam int DRIVE_W = 17;
    localparam int LED_W   = 16;
    localparam int AXIS_W  = 2;
    localparam int FS_W    = 16;

    // Arithmetic widths
    localparam int SUMSQ_W = 32;              // x^2+y^2+z^2 < 2^32
    localparam int RAD_W   = 62;              // sumsq << 30
    localparam int RES_W   = 63;              // root work register and trial value
    localparam int NUM_W   = 31;              // root or |comp| << 15
    localparam int QUO_W   = 16;              // quotient before clamping
    localparam int FRAC_SH = 15;              // Q2.15 scale shift
    localparam int RAD_SH  = 30;              // radicand scale shift
    localparam int CNT_W   = 5;

    // Step counts (last counter values)
    localparam logic [CNT_W-1:0] SQ_LAST   = CNT_W'(2);
    localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(31);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(15);

    // Constants
    localparam logic [FS_W-1:0]  FS_RESET = 16'd10240;  // 10.0 g
    localparam logic [LED_W-1:0] Q15_ONE  = 16'h8000;   // 1.0 in Q1.15

    // Opcodes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TAP    = 1'b1;

    // Axis codes
    localparam logic [AXIS_W-1:0] AXIS_X   = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y   = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z   = 2'd2;
    localparam logic [AXIS_W-1:0] AXIS_MAG = 2'd3;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQ,
        ST_RINIT,
        ST_ROOT,
        ST_MAGLD,
        ST_DIV,
        ST_DONE
    } amd_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic cnt_clr;
        logic load;
        logic advance;
        logic sq_step;
        logic root_init;
        logic root_step;
        logic div_step;
        logic mag_load;
        logic write_out;
    } amd_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic sq_done;
        logic root_done;
        logic div_done;
        logic comp_div_busy;
    } amd_stat_t;

endpackage

>>> rtl/amd_ifs.sv
`timescale 1ns / 1ps
// ============================================================================
// amd channel interfaces
// Valid/ready channels for samples, results and the full-scale register.
// ============================================================================
interface amd_in_if;
    import amd_pkg::*;
    logic                     valid;
    logic                     ready;
    logic                     opcode;
    logic signed [ACC_W-1:0]  accel_x;
    logic signed [ACC_W-1:0]  accel_y;
    logic signed [ACC_W-1:0]  accel_z;

    modport source (output valid, opcode, accel_x, accel_y, accel_z, input ready);
    modport sink   (input valid, opcode, accel_x, accel_y, accel_z, output ready);
endinterface

interface amd_out_if;
    import amd_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [DRIVE_W-1:0] motor_drive;
    logic [LED_W-1:0]          led_level;
    logic [AXIS_W-1:0]         axis_in_use;

    modport source (output valid, motor_drive, led_level, axis_in_use, input ready);
    modport sink   (input valid, motor_drive, led_level, axis_in_use, output ready);
endinterface

interface amd_cfg_if;
    import amd_pkg::*;
    logic            valid;
    logic            ready;
    logic [FS_W-1:0] full_scale_accel;

    modport source (output valid, full_scale_accel, input ready);
    modport sink   (input valid, full_scale_accel, output ready);
endinterface

>>> rtl/accel_axis_motor_drive.sv
`timescale 1ns / 1ps
// Sequence: a sample raises result valid after 3 square steps, root setup, 32 root iterations,
// magnitude load, 16 divider steps and the result write, which waits while a result is stalled;
// a double tap is handled in the idle state. One sample at a time, paced by the one-bit-per-cycle
// root loop and the 16-step magnitude division; the component division overlaps the root.
// Reset: full scale returns to 10.0 g, the axis to X, and no result is pending.
// ============================================================================
// accel_axis_motor_drive
// Accelerometer-driven motor drive and LED level with double-tap axis select.
// ============================================================================
module accel_axis_motor_drive
    import amd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    amd_in_if.sink    sample,
    amd_out_if.source result,
    amd_cfg_if.sink   cfg
);

    amd_cmd_t  cmd;
    amd_stat_t stat;

    // Register writes are always taken
    assign cfg.ready = 1'b1;

    // Sequencer
    amd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_opcode (sample.opcode),
        .in_ready  (sample.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    // Arithmetic and state
    amd_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .accel_x     (sample.accel_x),
        .accel_y     (sample.accel_y),
        .accel_z     (sample.accel_z),
        .cfg_we      (cfg.valid),
        .cfg_data    (cfg.full_scale_accel),
        .motor_drive (result.motor_drive),
        .led_level   (result.led_level),
        .axis_in_use (result.axis_in_use)
    );

endmodule

>>> rtl/amd_ctrl.sv
`timescale 1ns / 1ps
// ============================================================================
// amd_ctrl
// Sequencer: double taps, squares, root iterations, divisions and result handoff.
// ============================================================================
module amd_ctrl
    import amd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      in_opcode,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  amd_stat_t stat,
    output amd_cmd_t  cmd
);

    amd_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    // State and result-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.cnt_clr = 1'b1;
                if (in_valid)
                begin
                    if (in_opcode == OP_TAP)
                    begin
                        cmd.advance = 1'b1;
                    end
                    else
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_SQ;
                    end
                end
            end
            ST_SQ:
            begin
                cmd.sq_step = 1'b1;
                if (stat.sq_done)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = ST_RINIT;
                end
            end
            ST_RINIT:
            begin
                cmd.root_init = 1'b1;
                cmd.cnt_clr   = 1'b1;
                state_next    = ST_ROOT;
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                cmd.div_step  = stat.comp_div_busy;
                if (stat.root_done)
                begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = ST_MAGLD;
                end
            end
            ST_MAGLD:
            begin
                cmd.mag_load = 1'b1;
                cmd.cnt_clr  = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.write_out = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result slot: filled on write, emptied when taken
    always_comb
    begin
        if (cmd.write_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> rtl/amd_dp.sv
`timescale 1ns / 1ps
// ============================================================================
// amd_dp
// Datapath: sum of squares, bit-serial square root, restoring divider,
// axis state, full-scale register and result registers.
// ============================================================================
module amd_dp
    import amd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  amd_cmd_t                  cmd,
    output amd_stat_t                 stat,
    input  logic signed [ACC_W-1:0]   accel_x,
    input  logic signed [ACC_W-1:0]   accel_y,
    input  logic signed [ACC_W-1:0]   accel_z,
    input  logic                      cfg_we,
    input  logic [FS_W-1:0]           cfg_data,
    output logic signed [DRIVE_W-1:0] motor_drive,
    output logic [LED_W-1:0]          led_level,
    output logic [AXIS_W-1:0]         axis_in_use
);

    // Control state
    logic [FS_W-1:0]   fs_reg;
    logic [AXIS_W-1:0] axis_reg;
    logic [CNT_W-1:0]  cnt_reg;

    // Payload registers
    logic signed [ACC_W-1:0] x_reg, y_reg, z_reg;
    logic [AXIS_W-1:0]       cur_axis_reg;
    logic                    comp_neg_reg;
    logic [LED_W-1:0]        comp_mag_reg;
    logic [SUMSQ_W-1:0]      sumsq_reg;
    logic [RAD_W-1:0]        rad_reg;
    logic [RES_W-1:0]        res_reg;
    logic [RES_W-1:0]        bit_reg;
    logic [NUM_W-1:0]        rem_reg;
    logic [NUM_W-1:0]        dvs_reg;
    logic [QUO_W-1:0]        quo_reg;
    logic                    dzero_reg;
    logic                    dsat_reg;
    logic signed [DRIVE_W-1:0] drive_reg;
    logic [LED_W-1:0]          led_reg;
    logic [AXIS_W-1:0]         axis_out_reg;

    // Combinational helpers
    logic signed [ACC_W-1:0]   comp_in;
    logic signed [ACC_W:0]     comp_ext;
    logic [ACC_W-1:0]          comp_abs;
    logic signed [ACC_W-1:0]   sq_op;
    logic signed [2*ACC_W-1:0] sq_prod;
    logic [RES_W-1:0]          trial;
    logic                      root_take;
    logic [NUM_W-1:0]          div_num;
    logic [SUMSQ_W-1:0]        sat_thr;
    logic                      div_take;
    logic [LED_W-1:0]          div_result;
    logic [DRIVE_W-1:0]        comp_drive;

    // Full-scale register, axis select and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_reg   <= FS_RESET;
            axis_reg <= AXIS_X;
            cnt_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                fs_reg <= cfg_data;
            end
            if (cmd.advance)
            begin
                axis_reg <= axis_reg + AXIS_W'(1);
            end
            cnt_reg <= cmd.cnt_clr ? '0 : cnt_reg + CNT_W'(1);
        end
    end

    assign stat.sq_done       = (cnt_reg == SQ_LAST);
    assign stat.root_done     = (cnt_reg == ROOT_LAST);
    assign stat.div_done      = (cnt_reg == DIV_LAST);
    assign stat.comp_div_busy = (cnt_reg <= DIV_LAST);

    // Selected component magnitude
    always_comb
    begin
        case (axis_reg)
            AXIS_X:  comp_in = accel_x;
            AXIS_Y:  comp_in = accel_y;
            default: comp_in = accel_z;
        endcase
    end
    assign comp_ext = {comp_in[ACC_W-1], comp_in};
    assign comp_abs = comp_in[ACC_W-1] ? ACC_W'(-comp_ext) : ACC_W'(comp_ext);

    // Squarer operand: one component per step
    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    sq_op = x_reg;
            2'd1:    sq_op = y_reg;
            default: sq_op = z_reg;
        endcase
    end
    assign sq_prod = sq_op * sq_op;

    // Root trial value
    assign trial     = res_reg + bit_reg;
    assign root_take = ({1'b0, rad_reg} >= trial);

    // Divider operand and saturation threshold (32769 * fs)
    assign div_num  = cmd.load ? NUM_W'({comp_abs, FRAC_SH'(0)}) : res_reg[NUM_W-1:0];
    assign sat_thr  = {1'b0, fs_reg, FRAC_SH'(0)} + SUMSQ_W'(fs_reg);
    assign div_take = (rem_reg >= dvs_reg);

    // Clamped quotient
    always_comb
    begin
        if (dzero_reg)
        begin
            div_result = '0;
        end
        else if (dsat_reg)
        begin
            div_result = Q15_ONE;
        end
        else
        begin
            div_result = quo_reg;
        end
    end

    // Sample capture, squares and root iterations
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg        <= accel_x;
            y_reg        <= accel_y;
            z_reg        <= accel_z;
            cur_axis_reg <= axis_reg;
            comp_neg_reg <= comp_in[ACC_W-1];
            sumsq_reg    <= '0;
        end
        else if (cmd.sq_step)
        begin
            sumsq_reg <= sumsq_reg + $unsigned(sq_prod);
        end

        if (cmd.root_init)
        begin
            rad_reg <= {sumsq_reg, RAD_SH'(0)};
            res_reg <= '0;
            bit_reg <= {1'b1, (RES_W-1)'(0)};
        end
        else if (cmd.root_step)
        begin
            if (root_take)
            begin
                rad_reg <= rad_reg - trial[RAD_W-1:0];
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    // Restoring divider, shared by the component and magnitude quotients
    always_ff @(posedge clk)
    begin
        if (cmd.mag_load)
        begin
            comp_mag_reg <= div_result;
        end
        if (cmd.load || cmd.mag_load)
        begin
            rem_reg   <= div_num;
            dvs_reg   <= {fs_reg, FRAC_SH'(0)};
            quo_reg   <= '0;
            dzero_reg <= (div_num == '0);
            dsat_reg  <= ({1'b0, div_num} >= sat_thr);
        end
        else if (cmd.div_step)
        begin
            if (div_take)
            begin
                rem_reg <= rem_reg - dvs_reg;
            end
            quo_reg <= {quo_reg[QUO_W-2:0], div_take};
            dvs_reg <= dvs_reg >> 1;
        end
    end

    // Signed component drive
    assign comp_drive = comp_neg_reg ? -{1'b0, comp_mag_reg} : {1'b0, comp_mag_reg};

    // Result registers
    always_ff @(posedge clk)
    begin
        if (cmd.write_out)
        begin
            led_reg      <= div_result;
            axis_out_reg <= cur_axis_reg;
            if (cur_axis_reg == AXIS_MAG)
            begin
                drive_reg <= $signed({1'b0, div_result});
            end
            else
            begin
                drive_reg <= $signed(comp_drive);
            end
        end
    end

    assign motor_drive = drive_reg;
    assign led_level   = led_reg;
    assign axis_in_use = axis_out_reg;

endmodule

>>> rtl/amd_chk.sv
`timescale 1ns / 1ps
// ============================================================================
// amd_chk
// Port-level checks for the motor drive block, bound to the top level.
// ============================================================================
module amd_chk
    import amd_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic                      in_opcode,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic signed [DRIVE_W-1:0] motor_drive,
    input  logic [LED_W-1:0]          led_level,
    input  logic [AXIS_W-1:0]         axis_in_use
);

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(motor_drive)
            && $stable(led_level) && $stable(axis_in_use))
        else $error("result changed while stalled");

    // LED level never exceeds 1.0
    a_led_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> led_level <= Q15_ONE)
        else $error("led_level above 1.0");

    // Drive stays within plus or minus 1.0
    a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (motor_drive >= -17'sd32768) && (motor_drive <= 17'sd32768))
        else $error("motor_drive out of range");

    // On the magnitude axis the drive equals the LED level
    a_mag_axis: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (axis_in_use == AXIS_MAG) |-> motor_drive == $signed({1'b0, led_level}))
        else $error("magnitude drive differs from led_level");

    // A sample keeps the input busy while it is worked on
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (in_opcode == OP_SAMPLE) |=> !in_ready)
        else $error("input ready right after a sample");

endmodule

bind accel_axis_motor_drive amd_chk u_amd_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (sample.valid),
    .in_ready    (sample.ready),
    .in_opcode   (sample.opcode),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .motor_drive (result.motor_drive),
    .led_level   (result.led_level),
    .axis_in_use (result.axis_in_use)
);

>>> tb/accel_axis_motor_drive_test.sv
`timescale 1ns / 1ps
// ============================================================================
// accel_axis_motor_drive_test
// Self-checking bench for the accelerometer motor drive. A queue-fed driver
// sends samples and double taps with random gaps, a monitor takes results with
// random stalls, and a bit-exact predictor of the drive, the LED level and the
// selected axis checks every result in order. The full-scale register is
// swept through several values, zero and both extremes among them.
// ============================================================================
module accel_axis_motor_drive_test;
    import amd_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 64;     // longer than one sample's latency
    localparam int QUIET_LIMIT   = 2000;   // cycles with no transaction at all
    localparam int MAX_REPORTS   = 10;
    localparam int CHUNK_ITEMS   = 28;
    localparam int CHUNKS        = 4;

    typedef struct {
        logic                    opcode;
        logic signed [ACC_W-1:0] x;
        logic signed [ACC_W-1:0] y;
        logic signed [ACC_W-1:0] z;
    } accel_item_t;

    typedef struct {
        logic signed [DRIVE_W-1:0] drive;
        logic [LED_W-1:0]          led;
        logic [AXIS_W-1:0]         axis;
    } drive_result_t;

    logic clk = 1'b0;
    logic rst_n;

    amd_in_if  sample_if ();
    amd_out_if result_if ();
    amd_cfg_if cfg_if ();

    accel_axis_motor_drive u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    always #HALF_PERIOD clk = ~clk;

    accel_item_t   pending_items [$];
    drive_result_t expected_drive [$];

    logic [AXIS_W-1:0] axis_model = AXIS_X;
    logic [FS_W-1:0]   scale_model = FS_RESET;
    logic              sender_burst = 1'b0;
    logic              receiver_burst = 1'b0;
    int unsigned       send_wait;
    int unsigned       recv_wait;
    int unsigned       quiet_cycles = 0;
    int unsigned       failures = 0;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Bit-by-bit floor square root; the root of a 62-bit radicand fits in 32 bits
    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned r;
        longint unsigned trial;
        r = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = r | (64'd1 << b);
            if (trial * trial <= n)
                r = trial;
        end
        return r;
    endfunction

    // Quotient over full scale, clamped to 1.0; zero scale saturates nonzero values
    function automatic logic [DRIVE_W-1:0] scaled_ratio(input longint unsigned num,
                                                        input logic [FS_W-1:0] scale);
        longint unsigned q;
        if (num == 0)
            return '0;
        if (scale == 0)
            return DRIVE_W'(Q15_ONE);
        q = num / scale;
        return (q > Q15_ONE) ? DRIVE_W'(Q15_ONE) : DRIVE_W'(q);
    endfunction

    function automatic drive_result_t predict_drive(input logic signed [ACC_W-1:0] ax,
                                                    input logic signed [ACC_W-1:0] ay,
                                                    input logic signed [ACC_W-1:0] az,
                                                    input logic [AXIS_W-1:0] axis,
                                                    input logic [FS_W-1:0] scale);
        longint             cx;
        longint             cy;
        longint             cz;
        longint             comp;
        logic [DRIVE_W-1:0] mag_ratio;
        drive_result_t      r;
        cx = ax;
        cy = ay;
        cz = az;
        mag_ratio = scaled_ratio(floor_sqrt((cx * cx + cy * cy + cz * cz) << RAD_SH), scale);
        r.led  = mag_ratio[LED_W-1:0];
        r.axis = axis;
        case (axis)
            AXIS_X:  comp = cx;
            AXIS_Y:  comp = cy;
            AXIS_Z:  comp = cz;
            default: comp = 0;
        endcase
        // component quotient truncates toward zero, sign applied afterwards
        if (axis == AXIS_MAG)
            r.drive = $signed(mag_ratio);
        else if (comp < 0)
            r.drive = -$signed(scaled_ratio((-comp) << FRAC_SH, scale));
        else
            r.drive = $signed(scaled_ratio(comp << FRAC_SH, scale));
        return r;
    endfunction

    // Track register writes and accepted items
    always @(posedge clk) begin
        if (rst_n === 1'b1 && cfg_if.valid && cfg_if.ready)
            scale_model = cfg_if.full_scale_accel;
        if (rst_n === 1'b1 && sample_if.valid && sample_if.ready) begin
            if (sample_if.opcode == OP_TAP)
                axis_model = axis_model + 1'b1;
            else
                expected_drive.push_back(predict_drive(sample_if.accel_x, sample_if.accel_y,
                                                       sample_if.accel_z, axis_model,
                                                       scale_model));
        end
    end

    // ------------------------------------------------------------------
    // Sample driver
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n) begin : drive_samples
        accel_item_t next_item;
        if (!rst_n) begin
            sample_if.valid   <= 1'b0;
            sample_if.opcode  <= OP_SAMPLE;
            sample_if.accel_x <= '0;
            sample_if.accel_y <= '0;
            sample_if.accel_z <= '0;
            send_wait         <= 0;
        end else if (sample_if.valid && !sample_if.ready) begin
            // hold the transaction until it is taken
        end else if (send_wait != 0) begin
            sample_if.valid <= 1'b0;
            send_wait       <= send_wait - 1;
        end else if (pending_items.size() != 0) begin
            next_item = pending_items.pop_front();
            sample_if.valid   <= 1'b1;
            sample_if.opcode  <= next_item.opcode;
            sample_if.accel_x <= next_item.x;
            sample_if.accel_y <= next_item.y;
            sample_if.accel_z <= next_item.z;
            send_wait         <= sender_burst ? 0 : $urandom_range(0, 3);
        end else begin
            sample_if.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor and checker
    // ------------------------------------------------------------------
    task automatic note_failure(input string what);
        failures++;
        if (failures <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    always @(posedge clk or negedge rst_n) begin : check_results
        drive_result_t want;
        int unsigned   stall;
        if (!rst_n) begin
            result_if.ready <= 1'b0;
            recv_wait       <= 0;
        end else if (result_if.valid && result_if.ready) begin
            if (expected_drive.size() == 0) begin
                note_failure("result with nothing expected");
            end else begin
                want = expected_drive.pop_front();
                if (result_if.motor_drive !== want.drive)
                    note_failure($sformatf("motor_drive expected %0d got %0d",
                                           want.drive, result_if.motor_drive));
                if (result_if.led_level !== want.led)
                    note_failure($sformatf("led_level expected %0d got %0d",
                                           want.led, result_if.led_level));
                if (result_if.axis_in_use !== want.axis)
                    note_failure($sformatf("axis_in_use expected %0d got %0d",
                                           want.axis, result_if.axis_in_use));
            end
            // stall for the next result is counted in cycles it waits with valid high
            stall = receiver_burst ? 0 : $urandom_range(0, 3);
            recv_wait       <= stall;
            result_if.ready <= (stall == 0);
        end else if (!result_if.ready && (result_if.valid || recv_wait == 0)) begin
            if (recv_wait <= 1)
                result_if.ready <= 1'b1;
            if (recv_wait != 0)
                recv_wait <= recv_wait - 1;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: no transaction on any channel for too long
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        if ((sample_if.valid && sample_if.ready) || (result_if.valid && result_if.ready)
                || (cfg_if.valid && cfg_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic queue_item(input logic opcode, input logic signed [ACC_W-1:0] x,
                              input logic signed [ACC_W-1:0] y,
                              input logic signed [ACC_W-1:0] z);
        accel_item_t it;
        it.opcode = opcode;
        it.x      = x;
        it.y      = y;
        it.z      = z;
        pending_items.push_back(it);
    endtask

    // Mix of full range, small, extreme and mid-range values
    function automatic logic [ACC_W-1:0] random_accel();
        logic [ACC_W-1:0] v;
        case ($urandom_range(0, 5))
            0, 1: v = ACC_W'($urandom);
            2:    v = ACC_W'($urandom_range(0, 4095) - 2048);
            3: begin
                case ($urandom_range(0, 4))
                    0:       v = 16'h8000;
                    1:       v = 16'h7fff;
                    2:       v = 16'hffff;
                    3:       v = 16'h0001;
                    default: v = '0;
                endcase
            end
            default: begin
                v = ACC_W'($urandom_range(0, 20000));
                if ($urandom_range(0, 1) == 1)
                    v = -v;
            end
        endcase
        return v;
    endfunction

    // Wait until every result is in and the block has gone quiet
    task automatic settle();
        while (pending_items.size() != 0 || sample_if.valid === 1'b1
               || expected_drive.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_full_scale(input logic [FS_W-1:0] value);
        @(posedge clk);
        cfg_if.valid            <= 1'b1;
        cfg_if.full_scale_accel <= value;
        do
            @(posedge clk);
        while (!(cfg_if.valid && cfg_if.ready));
        cfg_if.valid <= 1'b0;
    endtask

    initial begin : stimulus
        logic [FS_W-1:0] scale_plan [$];
        logic            op;

        // known values on every input from time zero
        rst_n                   = 1'b0;
        sample_if.valid         = 1'b0;
        sample_if.opcode        = OP_SAMPLE;
        sample_if.accel_x       = '0;
        sample_if.accel_y       = '0;
        sample_if.accel_z       = '0;
        result_if.ready         = 1'b0;
        cfg_if.valid            = 1'b0;
        cfg_if.full_scale_accel = '0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset full scale, every axis, tap wrap
        queue_item(OP_SAMPLE, 0, 0, 0);
        queue_item(OP_SAMPLE, 32767, -32768, 0);
        queue_item(OP_SAMPLE, -32768, -32768, -32768);
        queue_item(OP_SAMPLE, -1, 1, 0);
        queue_item(OP_SAMPLE, 10240, 0, 0);
        queue_item(OP_TAP, -32768, 32767, -1);    // fields ignored, axis to Y
        queue_item(OP_SAMPLE, 100, -32768, 5);
        queue_item(OP_SAMPLE, 0, 5120, -5120);
        queue_item(OP_TAP, 0, 0, 0);              // Z
        queue_item(OP_SAMPLE, 0, 0, -32768);
        queue_item(OP_SAMPLE, 3, -4, 32767);
        queue_item(OP_TAP, 32767, 32767, 32767);  // magnitude
        queue_item(OP_SAMPLE, 32767, 32767, 32767);
        queue_item(OP_SAMPLE, 1, 0, 0);
        queue_item(OP_SAMPLE, -6000, 8000, 0);
        queue_item(OP_TAP, 1, -1, 1);             // wraps back to X
        queue_item(OP_SAMPLE, -20000, 3, 4);
        settle();

        // Register sweep with random traffic in each setting
        scale_plan = '{16'd1, 16'd65535, 16'd0, 16'd1024, FS_W'($urandom_range(1, 65535)),
                       FS_W'($urandom_range(1, 2048)), 16'd400, FS_RESET};
        foreach (scale_plan[p]) begin
            write_full_scale(scale_plan[p]);
            queue_item(OP_SAMPLE, 0, 0, 0);
            queue_item(OP_SAMPLE, -32768, -32768, -32768);
            for (int c = 0; c < CHUNKS; c++) begin
                sender_burst   = ($urandom_range(0, 3) == 0);
                receiver_burst = ($urandom_range(0, 3) == 0);
                for (int i = 0; i < CHUNK_ITEMS; i++) begin
                    op = ($urandom_range(0, 4) == 0) ? OP_TAP : OP_SAMPLE;
                    queue_item(op, random_accel(), random_accel(), random_accel());
                end
                // now and then let everything drain before sending more
                if ($urandom_range(0, 3) == 0)
                    settle();
                else
                    while (pending_items.size() != 0) @(posedge clk);
            end
            settle();
        end

        if (expected_drive.size() != 0)
            note_failure($sformatf("%0d results never arrived", expected_drive.size()));
        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> sim.f
rtl/amd_pkg.sv
rtl/amd_ifs.sv
rtl/amd_ctrl.sv
rtl/amd_dp.sv
rtl/accel_axis_motor_drive.sv
rtl/amd_chk.sv
tb/accel_axis_motor_drive_test.sv
